/* rtl/gmh_pkg.sv */
// ---------------------------------------------------------------------------
// gmh_pkg
// Shared types and constants for the grid max height map: word formats,
// register indexes, divider control and the sequencer states.
// ---------------------------------------------------------------------------
package gmh_pkg;

   localparam int MAX_CELLS_X_DEF = 64;
   localparam int MAX_CELLS_Y_DEF = 64;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_X_LOW        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_WIDTH_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_WIDTH_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CELLS_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CELLS_Y      = 3'd5;

   localparam logic OP_SAMPLE   = 1'b0;
   localparam logic OP_REPORT   = 1'b1;
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam int COORD_W      = 32;
   localparam int WIDTH_W      = 31;
   localparam int COUNT_W      = 7;
   localparam int CELL_INDEX_W = 12;
   localparam int MEAN_W       = 31;
   localparam int NARROW_W     = 32;   // dividend width of a binning division

   typedef struct packed {
      logic                       op;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
      logic [WIDTH_W-1:0]         radius;
      logic                       in_group;
   } req_type;

   typedef struct packed {
      logic                     kind;
      logic [CELL_INDEX_W-1:0]  cell_index;
      logic                     out_of_range;
      logic                     updated;
      logic [MEAN_W-1:0]        mean_height;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic wide;    // full-width dividend (report mean), else 32-bit binning
   } div_ctl_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START_X,
      ST_DIV_X,
      ST_START_Y,
      ST_DIV_Y,
      ST_INDEX,
      ST_READ,
      ST_UPDATE,
      ST_SUM,
      ST_SUM_END,
      ST_MEAN,
      ST_DIV_M,
      ST_RESP
   } gmh_state_type;

endpackage

/* rtl/gmh_div.sv */
// ---------------------------------------------------------------------------
// gmh_div
// Shared restoring divider, two quotient bits per cycle. Narrow requests
// divide a 32-bit dividend, wide requests the full DVD_W-bit dividend.
// ---------------------------------------------------------------------------
module gmh_div
   import gmh_pkg::*;
#(
   parameter int DVD_W = 46
) (
   input  logic                clock,
   input  logic                reset,
   input  div_ctl_type         ctl,
   input  logic [DVD_W-1:0]    dividend,
   input  logic [WIDTH_W-1:0]  divisor,
   output logic                done,
   output logic [DVD_W-1:0]    quotient
);

   localparam int WIDE_PAIRS   = DVD_W / 2;
   localparam int NARROW_PAIRS = NARROW_W / 2;
   localparam int PCNT_W       = $clog2(WIDE_PAIRS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [PCNT_W-1:0]   cnt_ff, cnt_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [WIDTH_W-1:0]  rem_ff, rem_in;
   logic [WIDTH_W-1:0]  dsr_ff, dsr_in;

   logic [DVD_W-1:0]    dvd_step;
   logic [WIDTH_W-1:0]  rem_step;
   logic [WIDTH_W:0]    rs;
   logic [WIDTH_W:0]    diff;
   logic                ge;

   // two dependent restoring steps
   always_comb begin
      rem_step = rem_ff;
      dvd_step = dvd_ff;
      rs       = '0;
      diff     = '0;
      ge       = 1'b0;
      for (int i = 0; i < 2; i++) begin
         rs       = {rem_step, dvd_step[DVD_W-1]};
         diff     = rs - {1'b0, dsr_ff};
         ge       = (rs >= {1'b0, dsr_ff});
         rem_step = ge ? diff[WIDTH_W-1:0] : rs[WIDTH_W-1:0];
         dvd_step = {dvd_step[DVD_W-2:0], ge};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dsr_in  = divisor;
         if (ctl.wide) begin
            dvd_in = dividend;
            cnt_in = PCNT_W'(WIDE_PAIRS);
         end else begin
            dvd_in = {dividend[NARROW_W-1:0], {(DVD_W-NARROW_W){1'b0}}};
            cnt_in = PCNT_W'(NARROW_PAIRS);
         end
      end else if (busy_ff) begin
         dvd_in = dvd_step;
         rem_in = rem_step;
         cnt_in = cnt_ff - PCNT_W'(1);
         if (cnt_ff == PCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

/* rtl/grid_max_height_map.sv */
// ---------------------------------------------------------------------------
// grid_max_height_map
// Peak height per grid cell, raised by particle samples, averaged on report.
// ---------------------------------------------------------------------------
// After reset the block sweeps the height store to zero, one cell per clock,
// over all MAX_CELLS_X*MAX_CELLS_Y cells (4096 at the defaults); req_ready
// stays low meanwhile, while register writes are taken. It handles one word
// at a time through a single shared divider that retires two quotient bits
// per clock. A sample, once accepted, runs two 32-bit binning divisions
// (each a load, two-bit restoring steps and done), then index, store read,
// update and response; a sample outside the grid or outside the group skips
// the read and update. A report reads the store once per cell in use, sums
// the peaks, then runs the mean division over the full DVD_W-bit dividend
// (DVD_W = 46 at the defaults); a report whose sum is not positive skips the
// division. The response register frees the input side as soon as a word is
// loaded into it.
module grid_max_height_map
   import gmh_pkg::*;
#(
   parameter int MAX_CELLS_X = MAX_CELLS_X_DEF,
   parameter int MAX_CELLS_Y = MAX_CELLS_Y_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH  = MAX_CELLS_X * MAX_CELLS_Y;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CX_W   = $clog2(MAX_CELLS_X + 1);
   localparam int CY_W   = $clog2(MAX_CELLS_Y + 1);
   localparam int COL_W  = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
   localparam int ROW_W  = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
   localparam int PROD_W = CX_W + ROW_W;
   localparam int CNT_W  = CX_W + CY_W;
   localparam int SUM_W  = COORD_W + 1 + ADDR_W;
   localparam int DVD_W  = SUM_W + (SUM_W % 2);

   // configuration registers
   logic signed [COORD_W-1:0] x_low_ff;
   logic signed [COORD_W-1:0] y_low_ff;
   logic [WIDTH_W-1:0]        cell_width_x_ff;
   logic [WIDTH_W-1:0]        cell_width_y_ff;
   logic [COUNT_W-1:0]        cells_x_ff;
   logic [COUNT_W-1:0]        cells_y_ff;

   gmh_state_type             state_ff, state_in;

   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic                      acc_vld_ff, acc_vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   req_type                   item_ff, item_in;
   logic                      oor_ff, oor_in;
   logic                      upd_ff, upd_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic [COORD_W-1:0]        z_ff, z_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [ADDR_W-1:0]         scan_ff, scan_in;
   logic [MEAN_W-1:0]         mean_ff, mean_in;

   // height store
   logic [COORD_W-1:0]        mem [DEPTH];
   logic [COORD_W-1:0]        rd_data_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [COORD_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]         mem_raddr;

   // divider
   div_ctl_type               div_ctl;
   logic [DVD_W-1:0]          div_dividend;
   logic [WIDTH_W-1:0]        div_divisor;
   logic                      div_done;
   logic [DVD_W-1:0]          div_quot;

   logic [31:0]               cx_wide, cy_wide;
   logic [CX_W-1:0]           cx;
   logic [CY_W-1:0]           cy;
   logic [CNT_W-1:0]          cell_count;
   logic [WIDTH_W-1:0]        wx, wy;
   logic [COORD_W:0]          dx, dy;
   logic [COORD_W:0]          z_full;
   logic [PROD_W-1:0]         idx_sum;
   logic [31:0]               idx_wide;
   logic                      accept;
   logic                      rsp_free;
   logic                      clr_last;
   logic                      scan_last;
   logic                      sum_pos;
   logic                      raise;

   // -------------------------------------------------------------------------
   // configuration
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff        <= '0;
         y_low_ff        <= '0;
         cell_width_x_ff <= WIDTH_W'(65536);
         cell_width_y_ff <= WIDTH_W'(65536);
         cells_x_ff      <= COUNT_W'(64);
         cells_y_ff      <= COUNT_W'(64);
      end else if (csr_we) begin
         case (csr_index)
            REG_X_LOW:        x_low_ff        <= csr_wdata[COORD_W-1:0];
            REG_Y_LOW:        y_low_ff        <= csr_wdata[COORD_W-1:0];
            REG_CELL_WIDTH_X: cell_width_x_ff <= csr_wdata[WIDTH_W-1:0];
            REG_CELL_WIDTH_Y: cell_width_y_ff <= csr_wdata[WIDTH_W-1:0];
            REG_CELLS_X:      cells_x_ff      <= csr_wdata[COUNT_W-1:0];
            REG_CELLS_Y:      cells_y_ff      <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective grid size and cell widths
   always_comb begin
      if (cells_x_ff == '0) begin
         cx_wide = 32'd1;
      end else if (32'(cells_x_ff) > 32'(MAX_CELLS_X)) begin
         cx_wide = 32'(MAX_CELLS_X);
      end else begin
         cx_wide = 32'(cells_x_ff);
      end
      if (cells_y_ff == '0) begin
         cy_wide = 32'd1;
      end else if (32'(cells_y_ff) > 32'(MAX_CELLS_Y)) begin
         cy_wide = 32'(MAX_CELLS_Y);
      end else begin
         cy_wide = 32'(cells_y_ff);
      end
   end

   assign cx         = cx_wide[CX_W-1:0];
   assign cy         = cy_wide[CY_W-1:0];
   assign cell_count = CNT_W'(cx) * CNT_W'(cy);
   assign wx         = (cell_width_x_ff == '0) ? WIDTH_W'(1) : cell_width_x_ff;
   assign wy         = (cell_width_y_ff == '0) ? WIDTH_W'(1) : cell_width_y_ff;

   assign dx = {item_ff.pos_x[COORD_W-1], item_ff.pos_x} - {x_low_ff[COORD_W-1], x_low_ff};
   assign dy = {item_ff.pos_y[COORD_W-1], item_ff.pos_y} - {y_low_ff[COORD_W-1], y_low_ff};

   assign z_full  = {item_ff.pos_z[COORD_W-1], item_ff.pos_z} + {2'b00, item_ff.radius};
   assign idx_sum = PROD_W'(cx) * PROD_W'(row_ff) + PROD_W'(col_ff);
   assign idx_wide = 32'(idx_ff);

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (32'(clr_ff) == 32'(DEPTH - 1));
   assign scan_last = (CNT_W'(scan_ff) == (cell_count - CNT_W'(1)));
   assign sum_pos   = (sum_ff > 0);
   assign raise     = ($signed(z_ff) > $signed(rd_data_ff));

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == OP_REPORT) ? ST_SUM : ST_START_X;
            end
         end
         ST_START_X: state_in = ST_DIV_X;
         ST_DIV_X:   if (div_done) state_in = ST_START_Y;
         ST_START_Y: state_in = ST_DIV_Y;
         ST_DIV_Y:   if (div_done) state_in = ST_INDEX;
         ST_INDEX:   state_in = (oor_ff || !item_ff.in_group) ? ST_RESP : ST_READ;
         ST_READ:    state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_RESP;
         ST_SUM:     if (scan_last) state_in = ST_SUM_END;
         ST_SUM_END: state_in = ST_MEAN;
         ST_MEAN:    state_in = sum_pos ? ST_DIV_M : ST_RESP;
         ST_DIV_M:   if (div_done) state_in = ST_RESP;
         ST_RESP:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      div_ctl.start = (state_ff == ST_START_X) || (state_ff == ST_START_Y) ||
                      ((state_ff == ST_MEAN) && sum_pos);
      div_ctl.wide  = (state_ff == ST_MEAN);
      div_dividend  = DVD_W'(dx[NARROW_W-1:0]);
      div_divisor   = wx;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = z_ff;
      mem_raddr     = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_START_Y: begin
            div_dividend = DVD_W'(dy[NARROW_W-1:0]);
            div_divisor  = wy;
         end
         ST_MEAN: begin
            div_dividend = DVD_W'(unsigned'(sum_ff));
            div_divisor  = WIDTH_W'(cell_count);
         end
         ST_UPDATE:  mem_we    = raise;
         ST_SUM:     mem_raddr = scan_ff;
         default: ;
      endcase
   end

   // -------------------------------------------------------------------------
   // datapath
   // -------------------------------------------------------------------------
   always_comb begin
      clr_in       = clr_ff;
      acc_vld_in   = (state_ff == ST_SUM);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      item_in      = item_ff;
      oor_in       = oor_ff;
      upd_in       = upd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      z_in         = z_ff;
      sum_in       = sum_ff;
      scan_in      = scan_ff;
      mean_in      = mean_ff;

      if (acc_vld_ff) begin
         sum_in = sum_ff + {{(SUM_W-COORD_W){rd_data_ff[COORD_W-1]}}, rd_data_ff};
      end

      if (accept) begin
         item_in = req_data;
         oor_in  = 1'b0;
         upd_in  = 1'b0;
         sum_in  = '0;
         scan_in = '0;
         mean_in = '0;
      end

      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + ADDR_W'(1);
         ST_DIV_X: begin
            if (div_done) begin
               oor_in = dx[COORD_W] || (div_quot[NARROW_W-1:0] >= 32'(cx));
               col_in = div_quot[COL_W-1:0];
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               oor_in = oor_ff || dy[COORD_W] || (div_quot[NARROW_W-1:0] >= 32'(cy));
               row_in = div_quot[ROW_W-1:0];
            end
         end
         ST_INDEX: begin
            idx_in = idx_sum[ADDR_W-1:0];
            // z + radius saturates on positive overflow only
            z_in   = (z_full[COORD_W:COORD_W-1] == 2'b01) ? 32'h7FFF_FFFF
                                                          : z_full[COORD_W-1:0];
         end
         ST_UPDATE: if (raise) upd_in = 1'b1;
         ST_SUM:    scan_in = scan_ff + ADDR_W'(1);
         ST_DIV_M:  if (div_done) mean_in = div_quot[MEAN_W-1:0];
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.kind         = (item_ff.op == OP_REPORT) ? KIND_REPORT : KIND_ACK;
               rsp_data_in.cell_index   = (item_ff.op == OP_REPORT || oor_ff) ? '0
                                          : idx_wide[CELL_INDEX_W-1:0];
               rsp_data_in.out_of_range = oor_ff;
               rsp_data_in.updated      = upd_ff;
               rsp_data_in.mean_height  = mean_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      oor_ff      <= oor_in;
      upd_ff      <= upd_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      idx_ff      <= idx_in;
      z_ff        <= z_in;
      sum_ff      <= sum_in;
      scan_ff     <= scan_in;
      mean_ff     <= mean_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   gmh_div #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/tb_grid_max_height_map.sv */
// ---------------------------------------------------------------------------
// tb_grid_max_height_map
// Self-checking bench for the grid max height map. A queue of request words
// feeds a valid/ready driver; a monitor predicts each accepted word against
// a shadow copy of the peak store and the grid registers, then checks every
// response word field by field. Grid settings change between phases while
// the block is idle; both sides idle at random, and the receiver holds off
// once for a long stretch.
// ---------------------------------------------------------------------------
module tb_grid_max_height_map;
   import gmh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;
   localparam logic [31:0]          ONE         = 32'h0001_0000;   // 1.0 in Q16.16
   localparam int                   RANDOM_ITEMS = 60;            // per grid setting
   localparam int                   STORE_CELLS  = MAX_CELLS_X_DEF * MAX_CELLS_Y_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the grid registers and the peak store
   logic signed [31:0]    cfg_x_low = '0;
   logic signed [31:0]    cfg_y_low = '0;
   logic [WIDTH_W-1:0]    cfg_width_x = 31'd65536;
   logic [WIDTH_W-1:0]    cfg_width_y = 31'd65536;
   logic [COUNT_W-1:0]    cfg_cells_x = 7'd64;
   logic [COUNT_W-1:0]    cfg_cells_y = 7'd64;
   logic signed [31:0]    peak_shadow [0:STORE_CELLS-1];

   req_type               req_backlog [$];
   rsp_type               rsp_due [$];
   int                    items_queued = 0;
   int                    items_accepted = 0;
   int                    rsp_seen = 0;
   int                    error_count = 0;
   int unsigned           send_idle = 35;
   int unsigned           recv_idle = 81;
   bit                    req_accepted = 1'b0;
   bit                    hold_done = 1'b0;
   int                    hold_left = 0;

   grid_max_height_map dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      for (int i = 0; i < STORE_CELLS; i++) peak_shadow[i] = '0;
   end

   function automatic longint clamp_count(logic [COUNT_W-1:0] n, int maxn);
      if (n == 0) return 1;
      if (int'(n) > maxn) return maxn;
      return longint'(n);
   endfunction

   function automatic longint width_used(logic [WIDTH_W-1:0] w);
      return (w == 0) ? 64'sd1 : longint'(w);
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if (n < 0 && q * d != n) q = q - 1;
      return q;
   endfunction

   // Bins a sample and raises the peak, or averages the peaks on a report.
   function automatic rsp_type height_map_step(req_type w);
      rsp_type r;
      longint  cx, cy, col, row, idx, z, sum;
      int      i;
      r = '0;
      cx = clamp_count(cfg_cells_x, MAX_CELLS_X_DEF);
      cy = clamp_count(cfg_cells_y, MAX_CELLS_Y_DEF);
      if (w.op == OP_REPORT) begin
         r.kind = KIND_REPORT;
         sum = 0;
         for (i = 0; i < cx * cy; i++) sum = sum + longint'(peak_shadow[i]);
         if (sum > 0) r.mean_height = MEAN_W'(sum / (cx * cy));
      end else begin
         r.kind = KIND_ACK;
         col = floor_quot(longint'(w.pos_x) - longint'(cfg_x_low), width_used(cfg_width_x));
         row = floor_quot(longint'(w.pos_y) - longint'(cfg_y_low), width_used(cfg_width_y));
         if (col < 0 || col >= cx || row < 0 || row >= cy) begin
            r.out_of_range = 1'b1;
         end else begin
            idx = col + cx * row;
            z = longint'(w.pos_z) + longint'(w.radius);
            if (z > 64'sh7FFF_FFFF) z = 64'sh7FFF_FFFF;
            r.cell_index = idx[CELL_INDEX_W-1:0];
            if (w.in_group && z > longint'(peak_shadow[idx])) begin
               peak_shadow[idx] = z[31:0];
               r.updated = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      error_count++;
      if (error_count <= 100) $display("MISMATCH rsp %0d: %s", rsp_seen, msg);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off once the backlog is deep
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_seen >= 120 && req_backlog.size() > 4) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor: predict on accept, check on response
   always @(posedge clock) begin : monitor
      rsp_type got, want;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_valid && req_ready;
         if (req_accepted) begin
            rsp_due.push_back(height_map_step(req_data));
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (rsp_due.size() == 0) begin
               flag_mismatch("response word with nothing outstanding");
            end else begin
               want = rsp_due.pop_front();
               got  = rsp_data;
               if (got.kind !== want.kind)
                  flag_mismatch($sformatf("kind got %0b want %0b", got.kind, want.kind));
               if (got.cell_index !== want.cell_index)
                  flag_mismatch($sformatf("cell_index got %0d want %0d",
                                          got.cell_index, want.cell_index));
               if (got.out_of_range !== want.out_of_range)
                  flag_mismatch($sformatf("out_of_range got %0b want %0b",
                                          got.out_of_range, want.out_of_range));
               if (got.updated !== want.updated)
                  flag_mismatch($sformatf("updated got %0b want %0b",
                                          got.updated, want.updated));
               if (got.mean_height !== want.mean_height)
                  flag_mismatch($sformatf("mean_height got %h want %h",
                                          got.mean_height, want.mean_height));
            end
         end
      end
   end

   task automatic queue_word(input req_type w);
      req_backlog.push_back(w);
      items_queued++;
   endtask

   function automatic req_type sample_word(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [30:0] r, logic g);
      req_type w;
      w.op = OP_SAMPLE;
      w.pos_x = x;
      w.pos_y = y;
      w.pos_z = z;
      w.radius = r;
      w.in_group = g;
      return w;
   endfunction

   // report word; the sample fields carry junk that the block must ignore
   function automatic req_type report_word();
      req_type     w;
      logic [31:0] rnd;
      rnd = $urandom;
      w = sample_word($urandom, $urandom, $urandom, rnd[30:0], rnd[31]);
      w.op = OP_REPORT;
      return w;
   endfunction

   function automatic longint boundary_coord(longint low, longint span);
      case ($urandom_range(3))
         0:       return low - 1;
         1:       return low;
         2:       return low + span - 1;
         default: return low + span;
      endcase
   endfunction

   function automatic req_type make_sample();
      req_type     w;
      longint      cx, cy, wx, wy, px, py, pz;
      logic [31:0] rnd;
      int unsigned sel;
      cx = clamp_count(cfg_cells_x, MAX_CELLS_X_DEF);
      cy = clamp_count(cfg_cells_y, MAX_CELLS_Y_DEF);
      wx = width_used(cfg_width_x);
      wy = width_used(cfg_width_y);
      sel = $urandom_range(99);
      if (sel < 80) begin
         px = longint'(cfg_x_low) + longint'($urandom_range(cx - 1)) * wx
              + longint'($urandom_range(wx - 1));
         py = longint'(cfg_y_low) + longint'($urandom_range(cy - 1)) * wy
              + longint'($urandom_range(wy - 1));
      end else if (sel < 90) begin
         px = boundary_coord(longint'(cfg_x_low), cx * wx);
         py = boundary_coord(longint'(cfg_y_low), cy * wy);
      end else begin
         px = longint'($urandom);
         py = longint'($urandom);
      end
      w = sample_word(px[31:0], py[31:0], '0, '0, ($urandom_range(99) < 85));
      rnd = $urandom;
      case ($urandom_range(3))
         0: begin
            w.pos_z  = $urandom;
            w.radius = rnd[30:0];
         end
         1: begin
            w.pos_z  = $urandom_range(1 << 20);
            w.radius = 31'($urandom_range(1 << 16));
         end
         2: begin  // near the top, often saturating
            w.pos_z  = 32'h7FFF_0000 + $urandom_range(16'hFFFF);
            w.radius = 31'($urandom_range(1 << 18));
         end
         default: begin
            pz = -longint'($urandom_range(1 << 24, 1));
            w.pos_z  = pz[31:0];
            w.radius = 31'($urandom_range(1 << 23));
         end
      endcase
      return w;
   endfunction

   task automatic fill_random(input int unsigned report_pct);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(99) < report_pct) queue_word(report_word());
         else queue_word(make_sample());
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (items_accepted != items_queued || rsp_due.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_X_LOW:        cfg_x_low   = val;
         REG_Y_LOW:        cfg_y_low   = val;
         REG_CELL_WIDTH_X: cfg_width_x = val[WIDTH_W-1:0];
         REG_CELL_WIDTH_Y: cfg_width_y = val[WIDTH_W-1:0];
         REG_CELLS_X:      cfg_cells_x = val[COUNT_W-1:0];
         REG_CELLS_Y:      cfg_cells_y = val[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // waits for the block to go idle, then rewrites the whole grid setup;
   // unused upper data bits carry junk
   task automatic set_grid(input logic [31:0] xl, input logic [31:0] yl,
                           input logic [31:0] wxv, input logic [31:0] wyv,
                           input logic [6:0] nx, input logic [6:0] ny);
      logic [31:0] junk;
      drain();
      repeat (4) @(negedge clock);
      junk = $urandom;
      write_reg(REG_X_LOW, xl);
      write_reg(REG_Y_LOW, yl);
      write_reg(REG_CELL_WIDTH_X, {junk[31], wxv[30:0]});
      write_reg(REG_CELL_WIDTH_Y, {junk[30], wyv[30:0]});
      write_reg(REG_CELLS_X, {junk[31:7], nx});
      write_reg(REG_CELLS_Y, {junk[24:0], ny});
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words on the reset grid: 64 x 64 cells of 1.0 from the origin
      queue_word(report_word());                                    // empty store
      queue_word(sample_word(0, 0, ONE, 0, 1'b1));
      queue_word(sample_word(0, 0, ONE, 0, 1'b1));                  // equal, no raise
      queue_word(sample_word(32'h8000, 32'h8000, ONE, 31'd1, 1'b1));
      queue_word(sample_word(5 * ONE, 0, 3 * ONE, 0, 1'b0));        // not in group
      queue_word(sample_word(32'hFFFF_FFFF, 0, ONE, 0, 1'b1));      // just left of grid
      queue_word(sample_word(64 * ONE, 0, ONE, 0, 1'b1));           // past last column
      queue_word(sample_word(0, 64 * ONE, ONE, 0, 1'b1));           // past last row
      queue_word(sample_word(0, 32'hFFFF_FFFF, ONE, 0, 1'b1));      // just below grid
      queue_word(sample_word(64 * ONE - 1, 64 * ONE - 1, 2 * ONE, 31'(ONE), 1'b1)); // last cell
      queue_word(sample_word(ONE, ONE, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1));     // saturates
      queue_word(sample_word(ONE, ONE, 32'h7FFF_FFFF, 0, 1'b1));
      queue_word(sample_word(2 * ONE, ONE, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1));
      queue_word(sample_word(2 * ONE, ONE, 32'h8000_0000, 0, 1'b1));
      queue_word(sample_word(32'h8000_0000, 32'h7FFF_FFFF, ONE, 0, 1'b1));
      queue_word(sample_word(32'h7FFF_FFFF, 32'h8000_0000, ONE, 0, 1'b1));
      queue_word(sample_word(3 * ONE, 2 * ONE, 32'hFFFF_0000, 31'h2_0000, 1'b1));
      queue_word(report_word());
      queue_word(report_word());

      // sender idles less than receiver
      set_grid(32'hFFFC_8000, 32'h0002_4000, 32'h0000_C000, 32'h0001_8000, 7'd8, 7'd5);
      fill_random(10);
      set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 7'd1, 7'd0);
      fill_random(10);
      set_grid($urandom, $urandom, $urandom_range(1 << 22, 1), $urandom_range(1 << 22, 1),
               7'($urandom_range(16, 1)), 7'($urandom_range(16, 1)));
      fill_random(10);

      // receiver idles less than sender
      send_idle = 81;
      recv_idle = 35;
      set_grid(0, 0, 32'd1, 32'd1, 7'd127, 7'd64);
      fill_random(3);
      drain();
      write_reg(REG_SPARE_6, $urandom);
      write_reg(REG_SPARE_7, $urandom);
      set_grid($urandom, $urandom, $urandom_range(1 << 22, 1), $urandom_range(1 << 22, 1),
               7'($urandom_range(16, 1)), 7'($urandom_range(16, 1)));
      fill_random(10);
      set_grid(32'h7FFF_0000, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 7'd100, 7'd2);
      fill_random(10);

      // full rate both ways
      send_idle = 0;
      recv_idle = 0;
      set_grid($urandom, $urandom, $urandom_range(1 << 22, 1), $urandom_range(1 << 22, 1),
               7'($urandom_range(16, 1)), 7'($urandom_range(16, 1)));
      fill_random(10);
      set_grid(32'hFFFF_0000, 32'hFFFF_0000, ONE, ONE, 7'd2, 7'd3);
      fill_random(20);
      set_grid($urandom, $urandom, $urandom_range(1 << 22, 1), $urandom_range(1 << 22, 1),
               7'($urandom_range(16, 1)), 7'($urandom_range(16, 1)));
      fill_random(10);

      drain();
      repeat (60) @(negedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
